>>> hdl/u8cu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8cu_pkg
// Types, constants and list helpers for the utf-8 to code unit transcoder.
// ----------------------------------------------------------------------------
package u8cu_pkg;

   localparam int MaxUnits = 4;
   localparam int UnitW    = 21;

   // unit_width_mode codes (any other code decodes as utf-32)
   localparam logic [1:0] ModeBytes = 2'd0;
   localparam logic [1:0] ModeUtf16 = 2'd1;

   localparam logic [7:0] ContMask  = 8'hC0;
   localparam logic [7:0] ContCode  = 8'h80;
   localparam logic [7:0] Lead2Mask = 8'hE0;
   localparam logic [7:0] Lead2Code = 8'hC0;
   localparam logic [7:0] Lead3Mask = 8'hF0;
   localparam logic [7:0] Lead3Code = 8'hE0;
   localparam logic [7:0] Lead4Mask = 8'hF8;
   localparam logic [7:0] Lead4Code = 8'hF0;
   localparam logic [7:0] Bits2Mask = 8'h1F;
   localparam logic [7:0] Bits3Mask = 8'h0F;
   localparam logic [7:0] Bits4Mask = 8'h07;

   localparam logic [UnitW-1:0] SuppBase = 21'h10000;
   localparam logic [15:0]      HiSurr   = 16'hD800;
   localparam logic [15:0]      LoSurr   = 16'hDC00;

   typedef struct packed {
      logic [MaxUnits-1:0][UnitW-1:0] unit;
      logic [MaxUnits-1:0]            raw;
      logic [2:0]                     cnt;
   } unit_list_type;

   function automatic unit_list_type list_put(unit_list_type l, logic [UnitW-1:0] u,
                                              logic r);
      unit_list_type o;
      o = l;
      if (l.cnt < 3'(MaxUnits)) begin
         o.unit[l.cnt[1:0]] = u;
         o.raw[l.cnt[1:0]]  = r;
         o.cnt              = l.cnt + 3'd1;
      end
      return o;
   endfunction

   function automatic unit_list_type list_put_point(unit_list_type l, logic [UnitW-1:0] v,
                                                    logic utf16);
      unit_list_type    o;
      logic [UnitW-1:0] u;
      u = v - SuppBase;
      if (utf16 && (v >= SuppBase)) begin
         o = list_put(l, {5'd0, HiSurr | {6'd0, u[19:10]}}, 1'b0);
         o = list_put(o, {5'd0, LoSurr | {6'd0, u[9:0]}}, 1'b0);
      end else begin
         o = list_put(l, v, 1'b0);
      end
      return o;
   endfunction

   // lead byte and the continuation bytes held so far, as raw units
   function automatic unit_list_type list_flush(unit_list_type l, logic [7:0] lead,
                                                logic [1:0] seen, logic [7:0] c0,
                                                logic [7:0] c1);
      unit_list_type o;
      o = list_put(l, {13'd0, lead}, 1'b1);
      if (seen >= 2'd1) begin
         o = list_put(o, {13'd0, c0}, 1'b1);
      end
      if (seen >= 2'd2) begin
         o = list_put(o, {13'd0, c1}, 1'b1);
      end
      return o;
   endfunction

endpackage : u8cu_pkg
`default_nettype wire

>>> hdl/utf8_to_code_units_transcoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_code_units_transcoder_top
// Lenient utf-8 decoder that emits byte, utf-16 or utf-32 code units.
// ----------------------------------------------------------------------------
// Order: an item taken is held in the input registers; its first unit is offered once it is loaded.
// Throughput: one item per cycle while each item yields at most one unit and rsp_tready
//    holds; an item yielding n units (up to 4) holds the output unit registers until all are taken.
// Reset: synchronous, clears mode to byte units, closes any open sequence and
//    empties the input and output registers.
module utf8_to_code_units_transcoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_wr_data,   // unit_width_mode
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,     // [7:0] src_byte
   input  wire logic        req_tlast,     // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,     // [20:0] code_unit, zero fill above
   output logic             rsp_tuser,     // [0] raw_fallback
   output logic             rsp_tlast      // run_last
);
   import u8cu_pkg::*;

   logic [1:0]  mode_ff;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   logic [7:0]       lead_ff, lead_in;
   logic [1:0]       needed_ff, needed_in;
   logic [1:0]       seen_ff, seen_in;
   logic [UnitW-1:0] point_ff, point_in;
   logic [7:0]       cont0_ff, cont0_in;
   logic [7:0]       cont1_ff, cont1_in;

   logic [MaxUnits-1:0][UnitW-1:0] units_ff;
   logic [MaxUnits-1:0]            raws_ff;
   logic [2:0]                     rem_ff;

   unit_list_type    lst;
   logic             fresh;
   logic             utf16;
   logic [UnitW-1:0] point_ext;
   logic             take;
   logic             load;

   assign utf16 = (mode_ff == ModeUtf16);
   assign take  = rsp_tvalid && rsp_tready;
   assign load  = in_valid_ff && ((rem_ff == 3'd0) || ((rem_ff == 3'd1) && take));
   assign req_tready = !in_valid_ff || load;

   assign point_ext = {point_ff[UnitW-7:0], in_byte_ff[5:0]};

   always_comb begin
      lst       = '0;
      fresh     = 1'b0;
      lead_in   = lead_ff;
      needed_in = needed_ff;
      seen_in   = seen_ff;
      point_in  = point_ff;
      cont0_in  = cont0_ff;
      cont1_in  = cont1_ff;

      if (mode_ff == ModeBytes) begin
         if (needed_ff != 2'd0) begin
            lst       = list_flush(lst, lead_ff, seen_ff, cont0_ff, cont1_ff);
            lead_in   = '0;
            needed_in = '0;
            seen_in   = '0;
            point_in  = '0;
         end
         lst = list_put(lst, {13'd0, in_byte_ff}, 1'b0);
      end else if (needed_ff != 2'd0) begin
         if ((in_byte_ff & ContMask) == ContCode) begin
            if (({1'b0, seen_ff} + 3'd1) >= {1'b0, needed_ff}) begin
               lead_in   = '0;
               needed_in = '0;
               seen_in   = '0;
               point_in  = '0;
               lst       = list_put_point(lst, point_ext, utf16);
            end else begin
               if (seen_ff[0]) begin
                  cont1_in = in_byte_ff;
               end else begin
                  cont0_in = in_byte_ff;
               end
               seen_in  = seen_ff + 2'd1;
               point_in = point_ext;
            end
         end else begin
            lst       = list_flush(lst, lead_ff, seen_ff, cont0_ff, cont1_ff);
            lead_in   = '0;
            needed_in = '0;
            seen_in   = '0;
            point_in  = '0;
            fresh     = 1'b1;
         end
      end else begin
         fresh = 1'b1;
      end

      if (fresh) begin
         if (!in_byte_ff[7]) begin
            lst = list_put_point(lst, {13'd0, in_byte_ff}, utf16);
         end else if ((in_byte_ff & Lead2Mask) == Lead2Code) begin
            lead_in   = in_byte_ff;
            needed_in = 2'd1;
            seen_in   = '0;
            point_in  = {13'd0, in_byte_ff & Bits2Mask};
         end else if ((in_byte_ff & Lead3Mask) == Lead3Code) begin
            lead_in   = in_byte_ff;
            needed_in = 2'd2;
            seen_in   = '0;
            point_in  = {13'd0, in_byte_ff & Bits3Mask};
         end else if ((in_byte_ff & Lead4Mask) == Lead4Code) begin
            lead_in   = in_byte_ff;
            needed_in = 2'd3;
            seen_in   = '0;
            point_in  = {13'd0, in_byte_ff & Bits4Mask};
         end else begin
            lst = list_put(lst, {13'd0, in_byte_ff}, 1'b1);
         end
      end

      // sequence cut off by the end of the literal
      if (in_last_ff && (needed_in != 2'd0)) begin
         lst       = list_flush(lst, lead_in, seen_in, cont0_in, cont1_in);
         lead_in   = '0;
         needed_in = '0;
         seen_in   = '0;
         point_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ModeBytes;
         in_valid_ff <= 1'b0;
         lead_ff     <= '0;
         needed_ff   <= '0;
         seen_ff     <= '0;
         point_ff    <= '0;
         rem_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (load) begin
            lead_ff   <= lead_in;
            needed_ff <= needed_in;
            seen_ff   <= seen_in;
            point_ff  <= point_in;
            rem_ff    <= lst.cnt;
         end else if (take) begin
            rem_ff <= rem_ff - 3'd1;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (load) begin
         cont0_ff <= cont0_in;
         cont1_ff <= cont1_in;
         units_ff <= lst.unit;
         raws_ff  <= lst.raw;
      end else if (take) begin
         units_ff[0] <= units_ff[1];
         units_ff[1] <= units_ff[2];
         units_ff[2] <= units_ff[3];
         raws_ff[0]  <= raws_ff[1];
         raws_ff[1]  <= raws_ff[2];
         raws_ff[2]  <= raws_ff[3];
      end
   end

   assign rsp_tvalid = (rem_ff != 3'd0);
   assign rsp_tdata  = {3'd0, units_ff[0]};
   assign rsp_tuser  = raws_ff[0];
   assign rsp_tlast  = (rem_ff == 3'd1);

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 3'(MaxUnits))
      else $error("unit count above list size");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("gap inside the units of one item");

   a_seq_count: assert property (@(posedge clock) disable iff (reset)
      (needed_ff != 2'd0) |-> (seen_ff < needed_ff))
      else $error("open sequence holds too many continuation bytes");

   a_closed_clean: assert property (@(posedge clock) disable iff (reset)
      (needed_ff == 2'd0) |-> ((seen_ff == 2'd0) && (lead_ff == 8'd0)))
      else $error("closed sequence left state behind");

endmodule : utf8_to_code_units_transcoder_top
`default_nettype wire
